// ===== sv/sdd_pkg.sv =====
// shared types, constants and a packing helper for the solenoid drop-detect controller
package sdd_pkg;

   // default number of valid readings averaged during calibration
   localparam int CALIB_SAMPLES_DEF = 3;

   localparam int MM_W    = 16;
   localparam int OP_W    = 2;
   localparam int PHASE_W = 2;
   localparam int OUTC_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // item kinds
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_READ = 2'd1;
   localparam logic [OP_W-1:0] OP_TRIG = 2'd2;

   // phases
   localparam logic [PHASE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] MODE_CALIB = 2'd1;
   localparam logic [PHASE_W-1:0] MODE_WATCH = 2'd2;
   localparam logic [PHASE_W-1:0] MODE_WAIT  = 2'd3;

   // outcomes
   localparam logic [OUTC_W-1:0] OUTC_NONE      = 2'd0;
   localparam logic [OUTC_W-1:0] OUTC_CAL_TO    = 2'd1;
   localparam logic [OUTC_W-1:0] OUTC_DROP      = 2'd2;
   localparam logic [OUTC_W-1:0] OUTC_REL_TO    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VALID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FALLBACK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_TO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REL_TO    = 3'd4;

   // register reset values
   localparam logic [MM_W-1:0] THRESHOLD_RST = 16'd30;
   localparam logic [MM_W-1:0] MAX_VALID_RST = 16'd2000;
   localparam logic [MM_W-1:0] FALLBACK_RST  = 16'd150;
   localparam logic [MM_W-1:0] CAL_TO_RST    = 16'd1000;
   localparam logic [MM_W-1:0] REL_TO_RST    = 16'd5000;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // rsp tdata: solenoid_on, led_on, phase, outcome, baseline_mm, zero fill
   function automatic logic [RSP_DATA_W-1:0] pack_rsp(input logic [PHASE_W-1:0] phase,
                                                      input logic [OUTC_W-1:0] outcome,
                                                      input logic [MM_W-1:0] baseline);
      logic on;
      on = (phase == MODE_CALIB) || (phase == MODE_WATCH);
      return {2'b00, baseline, outcome, phase, on, on};
   endfunction

endpackage

// ===== sv/sdd_div.sv =====
// shared restoring divider, one quotient bit per cycle
module sdd_div #(
   parameter int DW = 18,
   parameter int VW = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DW-1:0]         dividend,
   input  logic [VW-1:0]         divisor,
   output logic [DW-1:0]         quotient,
   output sdd_pkg::div_status_type status
);

   localparam int ITW = $clog2(DW);

   logic [VW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [VW-1:0]  div_ff, div_in;
   logic [ITW-1:0] it_ff, it_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   logic [VW:0]    shifted;
   logic [VW:0]    diff;
   logic           ge;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         it_in   = ITW'(DW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VW-1:0] : shifted[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         it_in  = it_ff - 1'b1;
         if (it_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      it_ff  <= it_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sv/solenoid_drop_detect_controller.sv =====
// top level: drop-detect sequencer, control registers and response register
//
// channel | direction | handshake           | payload
// req     | in        | req_tvalid/tready   | tuser op, tdata distance_mm, trigger_active
// rsp     | out       | rsp_tvalid/tready   | tdata solenoid_on .. baseline_mm
// csr     | in        | csr_valid/ready     | csr_index, csr_data
//
// most items are answered at once: the response is registered on the edge that accepts the item.
// an item that ends calibration with an average passes through S_DIV and S_WAIT while the shared
// divider produces one quotient bit per cycle; the response is registered when the divider is done.
// req_tready is low while the divider runs and while a response waits that is not being taken.
// reset is synchronous; csr writes are always taken.
module solenoid_drop_detect_controller #(
   parameter int CALIB_SAMPLES = sdd_pkg::CALIB_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] distance_mm, [16] trigger_active, [23:17] zero
   input  logic [sdd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] op
   input  logic [sdd_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] solenoid_on, [1] led_on, [3:2] phase, [5:4] outcome, [21:6] baseline_mm,
   // [23:22] zero
   output logic [sdd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sdd_pkg::MM_W-1:0]          csr_data
);

   localparam int MW    = sdd_pkg::MM_W;
   localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
   localparam int SUM_W = MW + CNT_W;

   // sequencer states
   localparam logic [1:0] S_READY = 2'd0;
   localparam logic [1:0] S_DIV   = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;

   logic [1:0]                     st_ff, st_in;
   logic [sdd_pkg::PHASE_W-1:0]    mode_ff, mode_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [MW-1:0]                  elapsed_ff, elapsed_in;
   logic [MW-1:0]                  baseline_ff, baseline_in;
   logic [sdd_pkg::OUTC_W-1:0]     outc_ff, outc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sdd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [MW-1:0] thr_ff, maxv_ff, fb_ff, calto_ff, relto_ff;

   logic [sdd_pkg::OP_W-1:0] op;
   logic [MW-1:0]            dist_mm;
   logic                     trig;
   logic                     accept;
   logic                     start_div;
   logic [SUM_W-1:0]         div_dividend;
   logic [CNT_W-1:0]         div_divisor;
   logic [SUM_W-1:0]         quotient;
   sdd_pkg::div_status_type  div_status;
   logic [SUM_W-1:0]         sum_add;
   logic [CNT_W-1:0]         cnt_add;
   logic [MW-1:0]            el_tick;

   assign op      = req_tuser;
   assign dist_mm = req_tdata[MW-1:0];
   assign trig    = req_tdata[MW];
   assign req_tready = (st_ff == S_READY) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;

   assign sum_add = sum_ff + SUM_W'(dist_mm);
   assign cnt_add = cnt_ff + 1'b1;
   assign el_tick = (elapsed_ff == {MW{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;

   sdd_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      st_in        = st_ff;
      mode_in      = mode_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      elapsed_in   = elapsed_ff;
      baseline_in  = baseline_ff;
      outc_in      = outc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      start_div    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = cnt_ff;

      case (st_ff)
         S_READY: begin
            if (accept) begin
               outc_in = sdd_pkg::OUTC_NONE;
               case (mode_ff)
                  sdd_pkg::MODE_IDLE: begin
                     if (op == sdd_pkg::OP_TRIG && trig) begin
                        mode_in    = sdd_pkg::MODE_CALIB;
                        sum_in     = '0;
                        cnt_in     = '0;
                        elapsed_in = '0;
                     end
                  end
                  sdd_pkg::MODE_CALIB: begin
                     if (op == sdd_pkg::OP_READ) begin
                        if (dist_mm != '0 && dist_mm < maxv_ff) begin
                           sum_in = sum_add;
                           cnt_in = cnt_add;
                           if (cnt_add >= CNT_W'(CALIB_SAMPLES)) begin
                              start_div    = 1'b1;
                              div_dividend = sum_add;
                              div_divisor  = cnt_add;
                              mode_in      = sdd_pkg::MODE_WATCH;
                              elapsed_in   = '0;
                           end
                        end
                     end else if (op == sdd_pkg::OP_TICK) begin
                        elapsed_in = el_tick;
                        if (el_tick > calto_ff) begin
                           outc_in    = sdd_pkg::OUTC_CAL_TO;
                           mode_in    = sdd_pkg::MODE_WATCH;
                           elapsed_in = '0;
                           if (cnt_ff != '0) begin
                              start_div = 1'b1;
                           end else begin
                              baseline_in = fb_ff;
                           end
                        end
                     end
                  end
                  sdd_pkg::MODE_WATCH: begin
                     if (op == sdd_pkg::OP_READ) begin
                        if (dist_mm != '0 && baseline_ff > thr_ff &&
                            dist_mm < baseline_ff - thr_ff) begin
                           mode_in = sdd_pkg::MODE_WAIT;
                           outc_in = sdd_pkg::OUTC_DROP;
                        end
                     end else if (op == sdd_pkg::OP_TICK) begin
                        elapsed_in = el_tick;
                        if (el_tick >= relto_ff) begin
                           mode_in = sdd_pkg::MODE_WAIT;
                           outc_in = sdd_pkg::OUTC_REL_TO;
                        end
                     end
                  end
                  default: begin
                     if (op == sdd_pkg::OP_TRIG && !trig) begin
                        mode_in = sdd_pkg::MODE_IDLE;
                     end
                  end
               endcase
               if (start_div) begin
                  st_in = S_DIV;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = sdd_pkg::pack_rsp(mode_in, outc_in, baseline_in);
               end
            end
         end
         S_DIV: begin
            // divider was launched on the accepting edge
            st_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_status.done) begin
               baseline_in  = quotient[MW-1:0];
               rsp_valid_in = 1'b1;
               rsp_data_in  = sdd_pkg::pack_rsp(mode_ff, outc_ff, quotient[MW-1:0]);
               st_in        = S_READY;
            end
         end
         default: begin
            st_in = S_READY;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_READY;
         mode_ff      <= sdd_pkg::MODE_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         elapsed_ff   <= '0;
         baseline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= sdd_pkg::THRESHOLD_RST;
         maxv_ff      <= sdd_pkg::MAX_VALID_RST;
         fb_ff        <= sdd_pkg::FALLBACK_RST;
         calto_ff     <= sdd_pkg::CAL_TO_RST;
         relto_ff     <= sdd_pkg::REL_TO_RST;
      end else begin
         st_ff        <= st_in;
         mode_ff      <= mode_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         elapsed_ff   <= elapsed_in;
         baseline_ff  <= baseline_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sdd_pkg::REG_THRESHOLD: thr_ff   <= csr_data;
               sdd_pkg::REG_MAX_VALID: maxv_ff  <= csr_data;
               sdd_pkg::REG_FALLBACK:  fb_ff    <= csr_data;
               sdd_pkg::REG_CAL_TO:    calto_ff <= csr_data;
               sdd_pkg::REG_REL_TO:    relto_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      outc_ff     <= outc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/solenoid_drop_detect_controller_tb.sv =====
// self-checking testbench for the solenoid drop-detect controller
module solenoid_drop_detect_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // op value with no meaning
   localparam logic [sdd_pkg::OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic                        solenoid_on;
      logic                        led_on;
      logic [sdd_pkg::PHASE_W-1:0] phase;
      logic [sdd_pkg::OUTC_W-1:0]  outcome;
      logic [sdd_pkg::MM_W-1:0]    baseline_mm;
   } status_type;

   typedef struct {
      logic [sdd_pkg::OP_W-1:0] op;
      logic [sdd_pkg::MM_W-1:0] distance_mm;
      logic                     trigger_active;
      bit                       typed;
      status_type               status;
   } table_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [sdd_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [sdd_pkg::OP_W-1:0]       req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sdd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [sdd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sdd_pkg::MM_W-1:0]       csr_data;

   // predicted register copies and controller state
   logic [sdd_pkg::MM_W-1:0]    cfg_threshold;
   logic [sdd_pkg::MM_W-1:0]    cfg_max_valid;
   logic [sdd_pkg::MM_W-1:0]    cfg_fallback;
   logic [sdd_pkg::MM_W-1:0]    cfg_cal_to;
   logic [sdd_pkg::MM_W-1:0]    cfg_rel_to;
   logic [sdd_pkg::PHASE_W-1:0] ctl_mode;
   int unsigned                 ctl_sum;
   int unsigned                 ctl_count;
   logic [sdd_pkg::MM_W-1:0]    ctl_elapsed;
   logic [sdd_pkg::MM_W-1:0]    ctl_baseline;

   status_type    pending_status_q[$];
   table_row_type directed_rows[$];
   int            mismatches = 0;
   int            sender_idle_pct = 23;
   int            receiver_idle_pct = 70;

   solenoid_drop_detect_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic status_type predict_status(input logic [sdd_pkg::OP_W-1:0] op,
                                                 input logic [sdd_pkg::MM_W-1:0] dist_mm,
                                                 input logic trig);
      status_type s;
      logic [sdd_pkg::OUTC_W-1:0] outc;
      outc = sdd_pkg::OUTC_NONE;
      case (ctl_mode)
         sdd_pkg::MODE_IDLE: begin
            if (op == sdd_pkg::OP_TRIG && trig) begin
               ctl_mode = sdd_pkg::MODE_CALIB;
               ctl_sum = 0;
               ctl_count = 0;
               ctl_elapsed = '0;
            end
         end
         sdd_pkg::MODE_CALIB: begin
            if (op == sdd_pkg::OP_READ) begin
               if (dist_mm != 0 && dist_mm < cfg_max_valid) begin
                  ctl_sum += dist_mm;
                  ctl_count++;
                  if (ctl_count >= sdd_pkg::CALIB_SAMPLES_DEF) begin
                     ctl_baseline = sdd_pkg::MM_W'(ctl_sum / ctl_count);
                     ctl_mode = sdd_pkg::MODE_WATCH;
                     ctl_elapsed = '0;
                  end
               end
            end else if (op == sdd_pkg::OP_TICK) begin
               if (ctl_elapsed != 16'hFFFF) ctl_elapsed++;
               if (ctl_elapsed > cfg_cal_to) begin
                  ctl_baseline = (ctl_count != 0) ? sdd_pkg::MM_W'(ctl_sum / ctl_count)
                                                  : cfg_fallback;
                  ctl_mode = sdd_pkg::MODE_WATCH;
                  ctl_elapsed = '0;
                  outc = sdd_pkg::OUTC_CAL_TO;
               end
            end
         end
         sdd_pkg::MODE_WATCH: begin
            if (op == sdd_pkg::OP_READ) begin
               if (dist_mm != 0 && ctl_baseline > cfg_threshold &&
                   dist_mm < ctl_baseline - cfg_threshold) begin
                  ctl_mode = sdd_pkg::MODE_WAIT;
                  outc = sdd_pkg::OUTC_DROP;
               end
            end else if (op == sdd_pkg::OP_TICK) begin
               if (ctl_elapsed != 16'hFFFF) ctl_elapsed++;
               if (ctl_elapsed >= cfg_rel_to) begin
                  ctl_mode = sdd_pkg::MODE_WAIT;
                  outc = sdd_pkg::OUTC_REL_TO;
               end
            end
         end
         default: begin
            if (op == sdd_pkg::OP_TRIG && !trig) ctl_mode = sdd_pkg::MODE_IDLE;
         end
      endcase
      s.solenoid_on = (ctl_mode == sdd_pkg::MODE_CALIB) || (ctl_mode == sdd_pkg::MODE_WATCH);
      s.led_on = s.solenoid_on;
      s.phase = ctl_mode;
      s.outcome = outc;
      s.baseline_mm = ctl_baseline;
      return s;
   endfunction

   // mostly items that suit the current phase, with some noise mixed in
   function automatic void pick_item(output logic [sdd_pkg::OP_W-1:0] op,
                                     output logic [sdd_pkg::MM_W-1:0] dist_mm,
                                     output logic trig);
      int roll;
      int near;
      roll = $urandom_range(0, 99);
      op = sdd_pkg::OP_TRIG;
      dist_mm = sdd_pkg::MM_W'($urandom);
      trig = 1'b1;
      if (roll < 12) begin
         op = sdd_pkg::OP_W'($urandom_range(0, 3));
         trig = 1'($urandom_range(0, 1));
         return;
      end
      roll = $urandom_range(0, 99);
      case (ctl_mode)
         sdd_pkg::MODE_IDLE: trig = (roll < 80);
         sdd_pkg::MODE_CALIB: begin
            if (roll < 20) begin
               op = sdd_pkg::OP_TICK;
            end else if (roll < 70) begin
               op = sdd_pkg::OP_READ;
               if (cfg_max_valid > 1)
                  dist_mm = sdd_pkg::MM_W'($urandom_range(1, cfg_max_valid - 1));
            end else if (roll < 90) begin
               op = sdd_pkg::OP_READ;
               dist_mm = (roll < 80) ? '0
                                     : sdd_pkg::MM_W'($urandom_range(cfg_max_valid, 65535));
            end
         end
         sdd_pkg::MODE_WATCH: begin
            if (roll < 35) begin
               op = sdd_pkg::OP_TICK;
            end else begin
               op = sdd_pkg::OP_READ;
               if (ctl_baseline > cfg_threshold && roll < 90) begin
                  // straddle the drop line
                  near = int'(ctl_baseline - cfg_threshold) + int'($urandom_range(0, 8)) - 3;
                  dist_mm = (near < 0) ? '0 : (near > 65535) ? 16'hFFFF
                                                              : sdd_pkg::MM_W'(near);
               end else if (roll < 95) begin
                  dist_mm = '0;
               end
            end
         end
         default: begin
            trig = (roll >= 60);
            if (roll >= 85) op = sdd_pkg::OP_TICK;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      status_type got;
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[3:2], rsp_tdata[5:4], rsp_tdata[21:6]};
         if (pending_status_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = pending_status_q.pop_front();
            check_field("solenoid_on", want.solenoid_on, got.solenoid_on);
            check_field("led_on", want.led_on, got.led_on);
            check_field("phase", want.phase, got.phase);
            check_field("outcome", want.outcome, got.outcome);
            check_field("baseline_mm", want.baseline_mm, got.baseline_mm);
         end
      end
   end

   always @(negedge clock) rsp_tready = ($urandom_range(0, 99) >= receiver_idle_pct);

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic drive_item(input logic [sdd_pkg::OP_W-1:0] op,
                             input logic [sdd_pkg::MM_W-1:0] dist_mm,
                             input logic trig, input bit typed,
                             input status_type typed_status);
      status_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {7'd0, trig, dist_mm};
      do @(posedge clock); while (!req_tready);
      predicted = predict_status(op, dist_mm, trig);
      pending_status_q.push_back(typed ? typed_status : predicted);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [sdd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sdd_pkg::MM_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sdd_pkg::REG_THRESHOLD: cfg_threshold = value;
         sdd_pkg::REG_MAX_VALID: cfg_max_valid = value;
         sdd_pkg::REG_FALLBACK:  cfg_fallback = value;
         sdd_pkg::REG_CAL_TO:    cfg_cal_to = value;
         sdd_pkg::REG_REL_TO:    cfg_rel_to = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // let every response arrive, then cover the divider latency
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending_status_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic apply_settings(input int thr, input int maxv, input int fb, input int cal,
                                 input int rel);
      settle();
      write_reg(sdd_pkg::REG_THRESHOLD, sdd_pkg::MM_W'(thr));
      write_reg(sdd_pkg::REG_MAX_VALID, sdd_pkg::MM_W'(maxv));
      write_reg(sdd_pkg::REG_FALLBACK, sdd_pkg::MM_W'(fb));
      write_reg(sdd_pkg::REG_CAL_TO, sdd_pkg::MM_W'(cal));
      write_reg(sdd_pkg::REG_REL_TO, sdd_pkg::MM_W'(rel));
   endtask

   task automatic add_row(input logic [sdd_pkg::OP_W-1:0] op, input int dist_mm,
                          input logic trig, input bit typed,
                          input logic [sdd_pkg::PHASE_W-1:0] phase,
                          input logic [sdd_pkg::OUTC_W-1:0] outc, input int base);
      table_row_type row;
      row.op = op;
      row.distance_mm = sdd_pkg::MM_W'(dist_mm);
      row.trigger_active = trig;
      row.typed = typed;
      row.status.solenoid_on = (phase == sdd_pkg::MODE_CALIB) ||
                               (phase == sdd_pkg::MODE_WATCH);
      row.status.led_on = row.status.solenoid_on;
      row.status.phase = phase;
      row.status.outcome = outc;
      row.status.baseline_mm = sdd_pkg::MM_W'(base);
      directed_rows.push_back(row);
   endtask

   initial begin
      logic [sdd_pkg::OP_W-1:0] op;
      logic [sdd_pkg::MM_W-1:0] dist_mm;
      logic                     trig;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = sdd_pkg::OP_TICK;
      csr_valid = 1'b0;
      csr_index = sdd_pkg::REG_THRESHOLD;
      csr_data = '0;
      cfg_threshold = sdd_pkg::THRESHOLD_RST;
      cfg_max_valid = sdd_pkg::MAX_VALID_RST;
      cfg_fallback = sdd_pkg::FALLBACK_RST;
      cfg_cal_to = sdd_pkg::CAL_TO_RST;
      cfg_rel_to = sdd_pkg::REL_TO_RST;
      ctl_mode = sdd_pkg::MODE_IDLE;
      ctl_sum = 0;
      ctl_count = 0;
      ctl_elapsed = '0;
      ctl_baseline = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values: threshold 30, readings valid below 2000
      add_row(sdd_pkg::OP_TICK, 0,     1'b0, 1, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(OP_SPARE,         65535, 1'b1, 1, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 65535, 1'b0, 1, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b0, 1, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b1, 1, sdd_pkg::MODE_CALIB, sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b1, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TICK, 0,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 0,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 2000,  1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 65535, 1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 1999,  1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(OP_SPARE,         65535, 1'b1, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 1,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      // third valid reading: baseline (1999 + 1 + 100) / 3
      add_row(sdd_pkg::OP_READ, 100,   1'b0, 1, sdd_pkg::MODE_WATCH, sdd_pkg::OUTC_NONE, 700);
      add_row(sdd_pkg::OP_READ, 0,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 670,   1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TICK, 0,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 669,   1'b0, 1, sdd_pkg::MODE_WAIT,  sdd_pkg::OUTC_DROP, 700);
      add_row(sdd_pkg::OP_TICK, 0,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_READ, 1,     1'b0, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b1, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b0, 1, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 700);
      add_row(sdd_pkg::OP_TRIG, 0,     1'b1, 0, sdd_pkg::MODE_IDLE,  sdd_pkg::OUTC_NONE, 0);
      foreach (directed_rows[i])
         drive_item(directed_rows[i].op, directed_rows[i].distance_mm,
                    directed_rows[i].trigger_active, directed_rows[i].typed,
                    directed_rows[i].status);

      for (int phase_idx = 0; phase_idx < 12; phase_idx++) begin
         settle();
         if (phase_idx < 4) begin
            sender_idle_pct = 23;
            receiver_idle_pct = 70;
         end else if (phase_idx < 8) begin
            sender_idle_pct = 70;
            receiver_idle_pct = 23;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         case (phase_idx)
            0:  apply_settings(20, 500, 150, 8, 12);
            1:  apply_settings(0, 65535, 0, 0, 0);
            2:  apply_settings(65535, 1, 65535, 3, 30);
            4:  apply_settings(5, 0, 400, 5, 6);
            6:  apply_settings(100, 65535, 65535, 65535, 20);
            11: apply_settings(10, 300, 200, 65535, 65535);
            default: apply_settings($urandom_range(0, 300), $urandom_range(1, 3000),
                                    $urandom_range(0, 65535), $urandom_range(0, 25),
                                    $urandom_range(0, 40));
         endcase
         repeat (140) begin
            pick_item(op, dist_mm, trig);
            drive_item(op, dist_mm, trig, 0, '0);
         end
      end

      settle();
      if (mismatches == 0 && pending_status_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
